// File: rtl/core/node_id_acquisition_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// Node-ID acquisition sequencer: assertion macros
// Small wrappers around concurrent assertions, used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef NODE_ID_ACQUISITION_SEQUENCER_UNIT_MACROS_SVH
`define NODE_ID_ACQUISITION_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define NIAS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define NIAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/nias_pkg.sv
// ----------------------------------------------------------------------------
// Node-ID acquisition sequencer package
// Types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package nias_pkg;

  // Bus master mode
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_POLL   = 2'd1,
    MODE_SET    = 2'd2
  } mode_e;

  // Outgoing message kinds
  localparam logic [2:0] KIND_POLL       = 3'd0;
  localparam logic [2:0] KIND_START_DATA = 3'd1;
  localparam logic [2:0] KIND_START_ACQ  = 3'd2;
  localparam logic [2:0] KIND_STOP_ACQ   = 3'd3;
  localparam logic [2:0] KIND_SET_ID     = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_NORMAL_PERIOD = 2'd0;
  localparam logic [1:0] REG_POLL_PERIOD   = 2'd1;
  localparam logic [1:0] REG_POLL_DURATION = 2'd2;
  localparam logic [1:0] REG_ASSIGN_PERIOD = 2'd3;

  // Register reset values
  localparam logic [15:0] RST_NORMAL_PERIOD = 16'd1000;
  localparam logic [15:0] RST_POLL_PERIOD   = 16'd100;
  localparam logic [15:0] RST_POLL_DURATION = 16'd2000;
  localparam logic [15:0] RST_ASSIGN_PERIOD = 16'd100;

  // Poll replies from this node are ignored
  localparam logic [7:0] BROADCAST_ID = 8'hFF;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // input transfer this cycle
    logic div_step;   // one remainder step
    logic eval;       // apply tick, fill message buffer
    logic emit_next;  // output transfer this cycle
  } nias_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_tick;    // offered item is a tick
    logic need_div;   // tick needs counter remainder
    logic div_last;   // final remainder step
    logic no_msg;     // evaluated tick gives no message
    logic emit_last;  // message on output is the last one
  } nias_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/node_id_acquisition_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Node-ID acquisition sequencer
// Bus master sequencer: keep-alive polling, acquisition start/stop and
// node ID assignment, driven by tick and node-message items.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid_i/in_stall_o  req_type, node_id, poll_reply,
//                                              acq_req, id_clear
//   out      from block out_valid_o/out_stall_i msg_kind, clear_flag,
//                                              assigned_id, last
//   cfg      to block   cfg_we_i               cfg_idx_i, cfg_data_i
//
// A node-message item is taken without leaving the idle state. A tick first
// runs a bit-serial counter remainder pass in acquire-poll mode with a nonzero
// poll period, then is evaluated and sends 0 to 4 messages, one per transfer.
// Output stalls hold the current message; the input stays stalled until the
// last message of the tick has been transferred.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "node_id_acquisition_sequencer_unit_macros.svh"

module node_id_acquisition_sequencer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  node_id_i,
  input  wire logic        poll_reply_i,
  input  wire logic        acq_req_i,
  input  wire logic        id_clear_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       msg_kind_o,
  output logic             clear_flag_o,
  output logic [7:0]       assigned_id_o,
  output logic             last_o
);
  import nias_pkg::*;

  nias_cmd_t cmd;
  nias_sts_t sts;

  nias_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  nias_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .node_id_i     (node_id_i),
    .poll_reply_i  (poll_reply_i),
    .acq_req_i     (acq_req_i),
    .id_clear_i    (id_clear_i),
    .msg_kind_o    (msg_kind_o),
    .clear_flag_o  (clear_flag_o),
    .assigned_id_o (assigned_id_o),
    .last_o        (last_o)
  );

  // No input transfer while a message is on offer
  `NIAS_ASSERT_IMPL(a_emit_blocks_in, clk_i, rst_ni, out_valid_o, in_stall_o, "input open during emit")
  // Valid drops after the last message of a tick
  `NIAS_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, out_valid_o && !out_stall_i && last_o, !out_valid_o, "emit past last message")
  // A node-message item does not stall the input after it is taken
  `NIAS_ASSERT_NEXT(a_msg_one_cycle, clk_i, rst_ni, in_valid_i && !in_stall_o && req_type_i, !in_stall_o, "message item held the input")

endmodule

`default_nettype wire

// File: rtl/core/nias_datapath.sv
// ----------------------------------------------------------------------------
// Node-ID acquisition sequencer datapath
// Config registers, mode/counter/ID state, bit-serial remainder unit and
// four-entry message buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module nias_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire nias_pkg::nias_cmd_t cmd_i,
  output nias_pkg::nias_sts_t    sts_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic              req_type_i,
  input  wire logic [7:0]        node_id_i,
  input  wire logic              poll_reply_i,
  input  wire logic              acq_req_i,
  input  wire logic              id_clear_i,
  output logic [2:0]             msg_kind_o,
  output logic                   clear_flag_o,
  output logic [7:0]             assigned_id_o,
  output logic                   last_o
);
  import nias_pkg::*;

  logic [15:0] normal_period_q, poll_period_q, poll_duration_q, assign_period_q;
  mode_e       mode_q, mode_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  highest_q, highest_d;
  logic [15:0] tinc_q;
  logic        acq_q, clr_q;
  logic [15:0] dvd_q;
  logic [15:0] rem_q;
  logic [3:0]  div_cnt_q;
  logic [16:0] rem_shift;
  logic [16:0] rem_sub;
  logic [2:0]  buf_kind_q [4];
  logic        buf_flag_q [4];
  logic [7:0]  buf_id_q   [4];
  logic [2:0]  ev_kind    [4];
  logic        ev_flag    [4];
  logic [7:0]  ev_id      [4];
  logic [2:0]  cnt_q, cnt_d;
  logic [1:0]  idx_q;
  logic        hit_normal, hit_poll, hit_assign, poll_done;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_period_q <= RST_NORMAL_PERIOD;
      poll_period_q   <= RST_POLL_PERIOD;
      poll_duration_q <= RST_POLL_DURATION;
      assign_period_q <= RST_ASSIGN_PERIOD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NORMAL_PERIOD: normal_period_q <= cfg_data_i;
        REG_POLL_PERIOD:   poll_period_q   <= cfg_data_i;
        REG_POLL_DURATION: poll_duration_q <= cfg_data_i;
        REG_ASSIGN_PERIOD: assign_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Status toward the controller
  assign sts_o.is_tick   = !req_type_i;
  assign sts_o.need_div  = (mode_q == MODE_POLL) && (poll_period_q != 16'd0);
  assign sts_o.div_last  = (div_cnt_q == 4'hF);
  assign sts_o.no_msg    = (cnt_d == 3'd0);
  assign sts_o.emit_last = ({1'b0, idx_q} == (cnt_q - 3'd1));

  // Restoring remainder step: tinc mod poll_period, one bit a cycle
  assign rem_shift = {rem_q, dvd_q[15]};
  assign rem_sub   = rem_shift - {1'b0, poll_period_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= 4'd0;
    end else if (cmd_i.load) begin
      div_cnt_q <= 4'd0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 4'd1;
    end
  end

  // Tick operands and remainder datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tinc_q <= tick_q + 16'd1;
      dvd_q  <= tick_q + 16'd1;
      rem_q  <= 16'd0;
      acq_q  <= acq_req_i;
      clr_q  <= id_clear_i;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[14:0], 1'b0};
      rem_q <= rem_sub[16] ? rem_shift[15:0] : rem_sub[15:0];
    end
  end

  // Tick evaluation: next state and message list
  assign hit_normal = (tinc_q == normal_period_q);
  assign hit_poll   = (poll_period_q != 16'd0) && (rem_q == 16'd0);
  assign hit_assign = (tinc_q == assign_period_q);
  assign poll_done  = (tinc_q >= poll_duration_q);

  always_comb begin
    mode_d    = mode_q;
    tick_d    = tick_q;
    highest_d = highest_q;
    cnt_d     = 3'd0;
    for (int i = 0; i < 4; i++) begin
      ev_kind[i] = KIND_POLL;
      ev_flag[i] = 1'b0;
      ev_id[i]   = 8'd0;
    end
    unique case (mode_q)
      MODE_NORMAL: begin
        tick_d = (hit_normal || acq_q) ? 16'd0 : tinc_q;
        if (acq_q) begin
          mode_d = MODE_POLL;
          if (clr_q) begin
            highest_d = 8'd0;
          end
        end
        unique case ({hit_normal, acq_q})
          2'b11: begin
            ev_kind[1] = KIND_START_DATA;
            ev_kind[2] = KIND_START_ACQ;
            ev_kind[3] = KIND_START_ACQ;
            ev_flag[2] = clr_q;
            ev_flag[3] = clr_q;
            cnt_d      = 3'd4;
          end
          2'b10: begin
            ev_kind[1] = KIND_START_DATA;
            cnt_d      = 3'd2;
          end
          2'b01: begin
            ev_kind[0] = KIND_START_ACQ;
            ev_kind[1] = KIND_START_ACQ;
            ev_flag[0] = clr_q;
            ev_flag[1] = clr_q;
            cnt_d      = 3'd2;
          end
          default: cnt_d = 3'd0;
        endcase
      end
      MODE_POLL: begin
        cnt_d = hit_poll ? 3'd1 : 3'd0;
        if (poll_done) begin
          mode_d = MODE_SET;
          tick_d = 16'd0;
        end else begin
          tick_d = tinc_q;
        end
      end
      MODE_SET: begin
        if (!acq_q) begin
          mode_d     = MODE_NORMAL;
          tick_d     = 16'd0;
          ev_kind[0] = KIND_STOP_ACQ;
          ev_kind[1] = KIND_STOP_ACQ;
          cnt_d      = 3'd2;
        end else if (hit_assign) begin
          tick_d     = 16'd0;
          ev_kind[1] = KIND_SET_ID;
          ev_id[1]   = highest_q + 8'd1;
          cnt_d      = 3'd2;
        end else begin
          tick_d = tinc_q;
        end
      end
      default: ;  // unused mode code holds everything
    endcase
  end

  // Mode, counter and highest node ID
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      tick_q    <= 16'd0;
      highest_q <= 8'd0;
    end else if (cmd_i.load && req_type_i) begin
      if (!(poll_reply_i && (node_id_i == BROADCAST_ID)) && (node_id_i > highest_q)) begin
        highest_q <= node_id_i;
      end
    end else if (cmd_i.eval) begin
      mode_q    <= mode_d;
      tick_q    <= tick_d;
      highest_q <= highest_d;
    end
  end

  // Message buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      for (int i = 0; i < 4; i++) begin
        buf_kind_q[i] <= ev_kind[i];
        buf_flag_q[i] <= ev_flag[i];
        buf_id_q[i]   <= ev_id[i];
      end
    end
  end

  // Buffer fill count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (cmd_i.eval) begin
      cnt_q <= cnt_d;
      idx_q <= 2'd0;
    end else if (cmd_i.emit_next) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // Output payload straight from the buffer
  assign msg_kind_o    = buf_kind_q[idx_q];
  assign clear_flag_o  = buf_flag_q[idx_q];
  assign assigned_id_o = buf_id_q[idx_q];
  assign last_o        = sts_o.emit_last;

endmodule

`default_nettype wire

// File: rtl/core/nias_ctrl.sv
// ----------------------------------------------------------------------------
// Node-ID acquisition sequencer controller
// One-hot state machine: accept, optional remainder pass, evaluate, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module nias_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output nias_pkg::nias_cmd_t      cmd_o,
  input  wire nias_pkg::nias_sts_t sts_i
);
  import nias_pkg::*;

  state_e state_q, state_d;

  // Handshake from state
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  // Commands
  assign cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.div_step  = (state_q == ST_DIV);
  assign cmd_o.eval      = (state_q == ST_EVAL);
  assign cmd_o.emit_next = (state_q == ST_EMIT) && !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.is_tick) begin
          state_d = sts_i.need_div ? ST_DIV : ST_EVAL;
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = sts_i.no_msg ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall_i && sts_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Node-ID acquisition sequencer testbench
// Drives ticks and node-message transfers through the valid/stall input,
// predicts every outgoing bus message and checks each output transfer.
// Covers directed mode walks, ID wrap, extreme and zero register values,
// and randomized phases with idles and backpressure on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import nias_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 17;
  localparam int unsigned NUM_PHASES   = 5;

  typedef struct {
    logic       req_type;
    logic [7:0] node_id;
    logic       poll_reply;
    logic       acq_req;
    logic       id_clear;
  } item_t;

  typedef struct {
    logic [2:0] kind;
    logic       clear_flag;
    logic [7:0] assigned_id;
    logic       last;
  } msg_t;

  // Bus master model plus queue of messages still owed by the block
  class acq_msg_scoreboard;
    logic [15:0] normal_period;
    logic [15:0] poll_period;
    logic [15:0] poll_duration;
    logic [15:0] assign_period;
    mode_e       mode;
    logic [15:0] tick_count;
    logic [7:0]  highest_id;
    msg_t        pending_msgs[$];
    msg_t        batch[$];
    int unsigned n_items;
    int unsigned n_ticks;
    int unsigned n_checked;
    int unsigned n_errors;

    function new();
      normal_period = RST_NORMAL_PERIOD;
      poll_period   = RST_POLL_PERIOD;
      poll_duration = RST_POLL_DURATION;
      assign_period = RST_ASSIGN_PERIOD;
      mode          = MODE_NORMAL;
      tick_count    = '0;
      highest_id    = '0;
      n_items       = 0;
      n_ticks       = 0;
      n_checked     = 0;
      n_errors      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_NORMAL_PERIOD: normal_period = val;
        REG_POLL_PERIOD:   poll_period   = val;
        REG_POLL_DURATION: poll_duration = val;
        REG_ASSIGN_PERIOD: assign_period = val;
        default: ;
      endcase
    endfunction

    function void add_msg(logic [2:0] kind, logic flag, logic [7:0] id);
      msg_t m;
      m.kind        = kind;
      m.clear_flag  = flag;
      m.assigned_id = id;
      m.last        = 1'b0;
      batch.push_back(m);
    endfunction

    // Advance the model by one accepted input transfer
    function void predict_item(item_t it);
      msg_t m;
      logic [7:0] next_id;
      n_items++;
      if (it.req_type) begin
        // poll replies from the broadcast ID never count as a node
        if (!(it.poll_reply && it.node_id == BROADCAST_ID) && it.node_id > highest_id)
          highest_id = it.node_id;
        return;
      end
      n_ticks++;
      batch.delete();
      case (mode)
        MODE_NORMAL: begin
          tick_count = tick_count + 16'd1;
          if (tick_count == normal_period) begin
            add_msg(KIND_POLL, 1'b0, 8'd0);
            add_msg(KIND_START_DATA, 1'b0, 8'd0);
            tick_count = '0;
          end
          if (it.acq_req) begin
            mode = MODE_POLL;
            if (it.id_clear) highest_id = '0;
            add_msg(KIND_START_ACQ, it.id_clear, 8'd0);
            add_msg(KIND_START_ACQ, it.id_clear, 8'd0);
            tick_count = '0;
          end
        end
        MODE_POLL: begin
          tick_count = tick_count + 16'd1;
          if (poll_period != 16'd0 && (tick_count % poll_period) == 16'd0)
            add_msg(KIND_POLL, 1'b0, 8'd0);
          if (tick_count >= poll_duration) begin
            mode = MODE_SET;
            tick_count = '0;
          end
        end
        MODE_SET: begin
          tick_count = tick_count + 16'd1;
          if (!it.acq_req) begin
            mode = MODE_NORMAL;
            add_msg(KIND_STOP_ACQ, 1'b0, 8'd0);
            add_msg(KIND_STOP_ACQ, 1'b0, 8'd0);
            tick_count = '0;
          end else if (tick_count == assign_period) begin
            next_id = highest_id + 8'd1;
            add_msg(KIND_POLL, 1'b0, 8'd0);
            add_msg(KIND_SET_ID, 1'b0, next_id);
            tick_count = '0;
          end
        end
        default: ;
      endcase
      foreach (batch[i]) begin
        m = batch[i];
        m.last = (i == batch.size() - 1);
        pending_msgs.push_back(m);
      end
    endfunction

    function void flag_error(string s);
      n_errors++;
      if (n_errors <= 10) $display("ERROR @%0t: %s", $time, s);
    endfunction

    // Compare one output transfer with the oldest owed message
    function void check_msg(msg_t got);
      msg_t exp;
      if (pending_msgs.size() == 0) begin
        flag_error($sformatf("unexpected message kind=%0d flag=%0b id=%0d last=%0b",
                             got.kind, got.clear_flag, got.assigned_id, got.last));
        return;
      end
      exp = pending_msgs.pop_front();
      n_checked++;
      if (got.kind !== exp.kind || got.clear_flag !== exp.clear_flag ||
          got.assigned_id !== exp.assigned_id || got.last !== exp.last)
        flag_error($sformatf({"message %0d: exp kind=%0d flag=%0b id=%0d last=%0b, ",
                              "got kind=%0d flag=%0b id=%0d last=%0b"}, n_checked,
                             exp.kind, exp.clear_flag, exp.assigned_id, exp.last,
                             got.kind, got.clear_flag, got.assigned_id, got.last));
    endfunction

    function int unsigned pending();
      return pending_msgs.size();
    endfunction
  endclass

  // Clock, reset and block ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        req_type_i    = 1'b0;
  logic [7:0]  node_id_i     = '0;
  logic        poll_reply_i  = 1'b0;
  logic        acq_req_i     = 1'b0;
  logic        id_clear_i    = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [2:0]  msg_kind_o;
  logic        clear_flag_o;
  logic [7:0]  assigned_id_o;
  logic        last_o;

  acq_msg_scoreboard sb;

  // Idle control, each written by a single process
  logic        tx_idle_en = 1'b0;
  logic        rx_idle_en = 1'b0;
  int unsigned holds_req  = 0;
  int unsigned holds_done = 0;
  int unsigned n_settings = 0;

  always #4 clk_i = ~clk_i;

  node_id_acquisition_sequencer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .node_id_i     (node_id_i),
    .poll_reply_i  (poll_reply_i),
    .acq_req_i     (acq_req_i),
    .id_clear_i    (id_clear_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .msg_kind_o    (msg_kind_o),
    .clear_flag_o  (clear_flag_o),
    .assigned_id_o (assigned_id_o),
    .last_o        (last_o)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offer one item and hold it until the input transfer happens
  task automatic send_item(input item_t it);
    in_valid_i   <= 1'b1;
    req_type_i   <= it.req_type;
    node_id_i    <= it.node_id;
    poll_reply_i <= it.poll_reply;
    acq_req_i    <= it.acq_req;
    id_clear_i   <= it.id_clear;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.predict_item(it);
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  // Tick: node fields are don't-care and get random values
  task automatic send_tick(input logic acq, input logic clr);
    item_t it;
    it.req_type   = 1'b0;
    it.node_id    = 8'($urandom);
    it.poll_reply = 1'($urandom);
    it.acq_req    = acq;
    it.id_clear   = clr;
    send_item(it);
  endtask

  // Node message: tick fields are don't-care
  task automatic send_msg(input logic [7:0] nid, input logic reply);
    item_t it;
    it.req_type   = 1'b1;
    it.node_id    = nid;
    it.poll_reply = reply;
    it.acq_req    = 1'($urandom);
    it.id_clear   = 1'($urandom);
    send_item(it);
  endtask

  // Random item, acquire biased by mode so the sequence goes deep
  function automatic item_t rand_item();
    item_t it;
    it.req_type   = ($urandom_range(0, 9) < 3);
    it.node_id    = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, 40));
    if ($urandom_range(0, 15) == 0) it.node_id = BROADCAST_ID;
    it.poll_reply = 1'($urandom);
    it.id_clear   = 1'($urandom);
    case (sb.mode)
      MODE_NORMAL: it.acq_req = ($urandom_range(0, 5) == 0);
      MODE_SET:    it.acq_req = ($urandom_range(0, 7) != 0);
      default:     it.acq_req = 1'($urandom);
    endcase
    return it;
  endfunction

  // Wait until the block owes nothing and has finished any silent tick
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers back to back
  task automatic set_regs(input logic [15:0] np, input logic [15:0] pp,
                          input logic [15:0] pd, input logic [15:0] ap);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    idx = '{REG_NORMAL_PERIOD, REG_POLL_PERIOD, REG_POLL_DURATION, REG_ASSIGN_PERIOD};
    val = '{np, pp, pd, ap};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Output side: random stalls plus the long hold-off on request
  initial begin : rx_stall
    forever begin
      @(posedge clk_i);
      if (holds_req != holds_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (gap_len()) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Output transfer monitor
  always @(posedge clk_i) begin : out_monitor
    msg_t got;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got.kind        = msg_kind_o;
      got.clear_flag  = clear_flag_o;
      got.assigned_id = assigned_id_o;
      got.last        = last_o;
      sb.check_msg(got);
    end
  end

  // Watchdog
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("FAIL node_id_acquisition_sequencer_unit");
    $finish;
  end

  initial begin : stimulus
    int unsigned errors;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: ID tracking, ignored broadcast reply, start acquisition
    send_msg(8'h12, 1'b0);
    send_msg(BROADCAST_ID, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    settle();

    // Zero poll period and duration; assign wrap; keep-alive with acquire start
    set_regs(16'd2, 16'd0, 16'd0, 16'd1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_msg(BROADCAST_ID, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    settle();

    // All registers at maximum, then a short acquire-poll phase
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_msg(8'h80, 1'b1);
    send_msg(8'h7F, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    settle();
    set_regs(16'hFFFF, 16'd1, 16'd3, 16'hFFFF);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    settle();

    // Random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       set_regs(16'd1, 16'd1, 16'd1, 16'd1);
        4:       set_regs(16'hFFFF, 16'd3, 16'd7, 16'd2);
        default: set_regs(16'($urandom_range(1, 6)), 16'($urandom_range(0, 4)),
                          16'($urandom_range(0, 10)), 16'($urandom_range(1, 5)));
      endcase
      tx_idle_en <= (p != 0);
      rx_idle_en <= (p != 0);
      // block fills up behind a long receiver hold-off
      if (p == 2) holds_req++;
      repeat (PHASE_ITEMS) send_item(rand_item());
      settle();
    end

    errors = sb.n_errors + sb.pending();
    $display("Run covered %0d input transfers (%0d ticks) under %0d register settings,",
             sb.n_items, sb.n_ticks, n_settings);
    $display("with %0d messages checked and %0d errors.", sb.n_checked, errors);
    if (errors == 0)
      $display("PASS node_id_acquisition_sequencer_unit");
    else
      $display("FAIL node_id_acquisition_sequencer_unit");
    $finish;
  end

endmodule
